FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define SGC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an implication holds in the cycle after the condition.
`define SGC_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);

`endif

FILE: hw/rtl/sgc_pkg.sv
// ----------------------------------------------------------------------------
// Sobol generator package
// Shared constants, item codes, sequencer states and bit search helpers.
// ----------------------------------------------------------------------------
package sgc_pkg;

    localparam int MAX_DIMS_DEF = 16;
    localparam int BITS_DEF     = 32;

    localparam logic [1:0] KIND_POLY   = 2'd0;
    localparam logic [1:0] KIND_INIT   = 2'd1;
    localparam logic [1:0] KIND_EXPAND = 2'd2;
    localparam logic [1:0] KIND_NEXT   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EXP_RD,
        ST_EXP_AC
    } sgc_state_t;

    // Degree of a polynomial: position of its top set bit above bit zero.
    function automatic logic [4:0] poly_degree(input logic [31:0] p);
        logic [4:0] d;
        d = 5'd0;
        for (int i = 1; i < 32; i++)
        begin
            if (p[i])
                d = 5'(i);
        end
        return d;
    endfunction

    // Position of the lowest zero bit, 32 when all bits are set.
    function automatic logic [5:0] lowest_zero(input logic [31:0] c);
        logic [5:0] l;
        l = 6'd32;
        for (int i = 31; i >= 0; i--)
        begin
            if (!c[i])
                l = 6'(i);
        end
        return l;
    endfunction

endpackage

FILE: hw/rtl/sobol_gray_code_generator.sv
// ----------------------------------------------------------------------------
// Sobol Gray-code point generator
// Load and init finish in ST_IDLE; expand alternates ST_EXP_RD and ST_EXP_AC per term.
// Next item: ST_RUN shifts all MAX_DIMS cells, held by back-pressure, emitting dim 0 first.
// Rate set by one ring rotation of the cells, one direction memory read per cell.
// Reset clears coordinates, counter, dims_reg=1; tables hold garbage until written.
// ----------------------------------------------------------------------------
module sobol_gray_code_generator #(
    parameter int MAX_DIMS = sgc_pkg::MAX_DIMS_DEF,
    parameter int BITS     = sgc_pkg::BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [3:0]  dim_sel,
    input  logic [4:0]  dir_index,
    input  logic [31:0] load_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  dim_out,
    output logic [31:0] coordinate,
    output logic        last,
    output logic        exhausted
);

    localparam int KW   = $clog2(BITS);
    localparam int DIMW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NW   = $clog2(MAX_DIMS + 1);
    localparam int AW   = $clog2(MAX_DIMS * BITS);

    function automatic logic [AW-1:0] dir_addr(input logic [DIMW-1:0] d,
                                               input logic [KW-1:0] k);
        return AW'(int'(d) * BITS + int'(k));
    endfunction

    sgc_pkg::sgc_state_t state_reg, state_next;

    logic [4:0]       dims_reg;
    logic [31:0]      cnt_reg, cnt_next;
    logic             first_reg, first_next;
    logic [5:0]       l_run_reg, l_run_next;
    logic             upd_reg, upd_next;
    logic             exh_reg, exh_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [DIMW-1:0]  idx_reg, idx_next;

    logic             out_valid_reg, out_valid_next;
    logic [3:0]       dim_out_reg;
    logic [BITS-1:0]  coord_reg;
    logic             last_reg, exh_out_reg;

    logic [31:0]      poly_mem [MAX_DIMS];
    logic [DIMW-1:0]  exp_dim_reg, exp_dim_next;
    logic [31:0]      poly_reg, poly_next;
    logic [KW-1:0]    s_reg, s_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [KW-1:0]    j_reg, j_next;
    logic [BITS-1:0]  acc_reg, acc_next;

    logic             accept, dim_ok, step, emit, apply;
    logic [DIMW-1:0]  sel_dim;
    logic [5:0]       lz;
    logic [4:0]       deg;
    logic [31:0]      sel_poly;
    logic [BITS-1:0]  term, acc_new, mix, head_val;
    logic [BITS+31:0] load_wide;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [BITS-1:0]  mem_wdata, rdata;

    logic [BITS-1:0]  cell_q [MAX_DIMS];

    assign in_ready = (state_reg == sgc_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign sel_dim  = DIMW'(dim_sel);
    assign dim_ok   = (32'(dim_sel) < MAX_DIMS);
    assign lz       = sgc_pkg::lowest_zero(cnt_reg);
    assign sel_poly = poly_mem[sel_dim];
    assign deg      = sgc_pkg::poly_degree(sel_poly);
    assign load_wide = {{BITS{1'b0}}, load_value} << (KW'(BITS - 1) - KW'(dir_index));

    assign step  = (state_reg == sgc_pkg::ST_RUN) && (!out_valid_reg || out_ready);
    assign emit  = step && (NW'(idx_reg) < n_reg);
    assign apply = upd_reg && (NW'(idx_reg) < n_reg);
    assign mix   = apply ? rdata : '0;
    assign head_val = cell_q[0] ^ mix;

    assign term = (j_reg == s_reg) ? (rdata ^ (rdata >> s_reg))
                : (poly_reg[5'(s_reg - j_reg)] ? rdata : '0);
    assign acc_new = acc_reg ^ term;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        first_next   = first_reg;
        l_run_next   = l_run_reg;
        upd_next     = upd_reg;
        exh_next     = exh_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        exp_dim_next = exp_dim_reg;
        poly_next    = poly_reg;
        s_next       = s_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        acc_next     = acc_reg;
        mem_we       = 1'b0;
        mem_waddr    = dir_addr(sel_dim, KW'(dir_index));
        mem_wdata    = load_wide[BITS-1:0];
        mem_raddr    = dir_addr('0, lz[KW-1:0]);
        unique case (state_reg)
            sgc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        sgc_pkg::KIND_POLY:
                        begin
                        end
                        sgc_pkg::KIND_INIT:
                            mem_we = dim_ok && (32'(dir_index) < BITS);
                        sgc_pkg::KIND_EXPAND:
                        begin
                            if (dim_ok && deg != 5'd0 && 32'(deg) < BITS)
                            begin
                                exp_dim_next = sel_dim;
                                poly_next    = sel_poly;
                                s_next       = KW'(deg);
                                k_next       = KW'(deg);
                                j_next       = KW'(deg);
                                acc_next     = '0;
                                state_next   = sgc_pkg::ST_EXP_RD;
                            end
                        end
                        sgc_pkg::KIND_NEXT:
                        begin
                            idx_next   = '0;
                            l_run_next = lz;
                            upd_next   = 1'b0;
                            exh_next   = 1'b0;
                            if (dims_reg == 5'd0)
                                n_next = NW'(1);
                            else if (32'(dims_reg) > MAX_DIMS)
                                n_next = NW'(MAX_DIMS);
                            else
                                n_next = NW'(dims_reg);
                            if (first_reg)
                                first_next = 1'b0;
                            else if (32'(lz) >= BITS)
                                exh_next = 1'b1;
                            else
                            begin
                                upd_next = 1'b1;
                                cnt_next = cnt_reg + 32'd1;
                            end
                            state_next = sgc_pkg::ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sgc_pkg::ST_RUN:
            begin
                if (step)
                begin
                    if (32'(idx_reg) == MAX_DIMS - 1)
                        state_next = sgc_pkg::ST_IDLE;
                    else
                        idx_next = idx_reg + DIMW'(1);
                end
                mem_raddr = dir_addr(idx_next, l_run_reg[KW-1:0]);
            end
            sgc_pkg::ST_EXP_RD:
            begin
                mem_raddr  = dir_addr(exp_dim_reg, k_reg - j_reg);
                state_next = sgc_pkg::ST_EXP_AC;
            end
            sgc_pkg::ST_EXP_AC:
            begin
                state_next = sgc_pkg::ST_EXP_RD;
                if (j_reg == KW'(1))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dir_addr(exp_dim_reg, k_reg);
                    mem_wdata = acc_new;
                    acc_next  = '0;
                    j_next    = s_reg;
                    if (32'(k_reg) == BITS - 1)
                        state_next = sgc_pkg::ST_IDLE;
                    else
                        k_next = k_reg + KW'(1);
                end
                else
                begin
                    acc_next = acc_new;
                    j_next   = j_reg - KW'(1);
                end
            end
            default:
                state_next = sgc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sgc_pkg::ST_IDLE;
            dims_reg      <= 5'd1;
            cnt_reg       <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            upd_reg       <= 1'b0;
            exh_reg       <= 1'b0;
            n_reg         <= NW'(1);
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write)
                dims_reg  <= cfg_data;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            upd_reg       <= upd_next;
            exh_reg       <= exh_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_run_reg   <= l_run_next;
        exp_dim_reg <= exp_dim_next;
        poly_reg    <= poly_next;
        s_reg       <= s_next;
        k_reg       <= k_next;
        j_reg       <= j_next;
        acc_reg     <= acc_next;
        if (accept && kind == sgc_pkg::KIND_POLY && dim_ok)
            poly_mem[sel_dim] <= load_value;
        if (emit)
        begin
            dim_out_reg <= 4'(idx_reg);
            coord_reg   <= head_val;
            last_reg    <= (NW'(idx_reg) == n_reg - NW'(1));
            exh_out_reg <= exh_reg;
        end
    end

    // Ring of coordinate cells; the tail takes the head with its update mixed in.
    for (genvar i = 0; i < MAX_DIMS; i++)
    begin : g_cell
        if (i == MAX_DIMS - 1)
        begin : g_tail
            sgc_cell #(.W(BITS)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (step),
                .din   (cell_q[0]),
                .mix   (mix),
                .q     (cell_q[i])
            );
        end
        else
        begin : g_body
            sgc_cell #(.W(BITS)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (step),
                .din   (cell_q[i+1]),
                .mix   ({BITS{1'b0}}),
                .q     (cell_q[i])
            );
        end
    end

    sgc_dir_mem #(.DEPTH(MAX_DIMS * BITS), .W(BITS), .AW(AW)) u_dir_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    assign out_valid  = out_valid_reg;
    assign dim_out    = dim_out_reg;
    assign coordinate = 32'(coord_reg);
    assign last       = last_reg;
    assign exhausted  = exh_out_reg;

`include "assert_macros.svh"

    `SGC_ASSERT(a_out_from_run, $rose(out_valid_reg) |-> $past(state_reg == sgc_pkg::ST_RUN), "result item raised outside a point run")
    `SGC_ASSERT(a_no_write_in_run, (state_reg == sgc_pkg::ST_RUN) |-> !mem_we, "direction memory written during a point run")
    `SGC_ASSERT_NEXT(a_cnt_hold, (state_reg == sgc_pkg::ST_RUN), (state_reg != sgc_pkg::ST_RUN) || $stable(cnt_reg), "point counter moved during a run")

endmodule

FILE: hw/rtl/sgc_cell.sv
// ----------------------------------------------------------------------------
// Sobol coordinate cell
// Holds one coordinate; on shift it takes its neighbor's value XOR a mix word.
// ----------------------------------------------------------------------------
module sgc_cell #(
    parameter int W = sgc_pkg::BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         shift,
    input  logic [W-1:0] din,
    input  logic [W-1:0] mix,
    output logic [W-1:0] q
);

    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (shift)
            val_next = din ^ mix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            val_reg <= '0;
        else
            val_reg <= val_next;
    end

    assign q = val_reg;

endmodule

FILE: hw/rtl/sgc_dir_mem.sv
// ----------------------------------------------------------------------------
// Direction number memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sgc_dir_mem #(
    parameter int DEPTH = sgc_pkg::MAX_DIMS_DEF * sgc_pkg::BITS_DEF,
    parameter int W     = sgc_pkg::BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobol Gray-code generator testbench
// Drives load, expand and next items with random idling on both channels,
// predicts every coordinate in a scoreboard class and compares in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NDIM = 16;
    localparam int NBIT = 32;

    typedef struct packed {
        logic [3:0]  dim;
        logic [31:0] coord;
        logic        last;
        logic        exh;
    } coord_t;

    class sobol_scoreboard;
        logic [31:0] polys[NDIM];
        logic [31:0] dirs[NDIM][NBIT];
        logic [31:0] coords[NDIM];
        logic [31:0] counter;
        bit          first;
        logic [4:0]  dims_reg;
        coord_t      pending[$];
        int          errors;
        int          points;
        int          exh_seen;

        function void reset_state();
            foreach (coords[i]) coords[i] = '0;
            foreach (polys[i]) polys[i] = '0;
            foreach (dirs[i, j]) dirs[i][j] = '0;
            counter = '0;
            first = 1;
            dims_reg = 5'd1;
        endfunction

        function void expand(int d);
            int s;
            logic [31:0] acc;
            s = 0;
            for (int i = 1; i < 32; i++)
                if (polys[d][i]) s = i;
            if (s == 0) return;
            for (int k = s; k < NBIT; k++)
            begin
                acc = dirs[d][k - s] ^ (dirs[d][k - s] >> s);
                for (int i = 1; i < s; i++)
                    if (polys[d][s - i]) acc ^= dirs[d][k - i];
                dirs[d][k] = acc;
            end
        endfunction

        function void note_item(logic [1:0] k, logic [3:0] d, logic [4:0] idx,
                                logic [31:0] val);
            int n;
            int l;
            bit ex;
            coord_t c;
            ex = 0;
            if (k == sgc_pkg::KIND_POLY) polys[d] = val;
            else if (k == sgc_pkg::KIND_INIT) dirs[d][idx] = val << (NBIT - 1 - idx);
            else if (k == sgc_pkg::KIND_EXPAND) expand(d);
            else
            begin
                n = dims_reg;
                if (n == 0) n = 1;
                if (n > NDIM) n = NDIM;
                if (first) first = 0;
                else
                begin
                    l = 0;
                    while (l < 32 && counter[l]) l++;
                    if (l >= NBIT) ex = 1;
                    else
                    begin
                        for (int i = 0; i < n; i++) coords[i] ^= dirs[i][l];
                        counter = counter + 1;
                    end
                end
                points++;
                if (ex) exh_seen++;
                for (int i = 0; i < n; i++)
                begin
                    c.dim = 4'(i);
                    c.coord = coords[i];
                    c.last = (i == n - 1);
                    c.exh = ex;
                    pending.push_back(c);
                end
            end
        endfunction

        function void check_result(coord_t got);
            coord_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected coordinate dim %0d value %h", got.dim, got.coord);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.dim !== e.dim)
            begin
                $error("dim_out expected %0d actual %0d", e.dim, got.dim);
                errors++;
            end
            if (got.coord !== e.coord)
            begin
                $error("coordinate expected %h actual %h", e.coord, got.coord);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last expected %0b actual %0b", e.last, got.last);
                errors++;
            end
            if (got.exh !== e.exh)
            begin
                $error("exhausted expected %0b actual %0b", e.exh, got.exh);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [4:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [3:0]  dim_sel;
    logic [4:0]  dir_index;
    logic [31:0] load_value;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  dim_out;
    logic [31:0] coordinate;
    logic        last;
    logic        exhausted;

    sobol_scoreboard sb;
    bit   no_idle;

    sobol_gray_code_generator dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .dim_sel(dim_sel),
        .dir_index(dir_index), .load_value(load_value), .out_valid(out_valid),
        .out_ready(out_ready), .dim_out(dim_out), .coordinate(coordinate),
        .last(last), .exhausted(exhausted)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("tb_top NOT OK");
        $finish;
    end

    // Drain side: random stall, check on each handshake.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                sb.check_result('{dim_out, coordinate, last, exhausted});
            out_ready <= no_idle || ($urandom_range(99) >= 27);
        end
    end

    // Hold valid after the handshake; the next item or an idle cycle replaces it.
    task automatic send_item(logic [1:0] k, logic [3:0] d, logic [4:0] idx,
                             logic [31:0] val);
        while (!no_idle && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        dim_sel    <= d;
        dir_index  <= idx;
        load_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(k, d, idx, val);
    endtask

    // Drop valid, wait for all coordinates, then cover a possible expand still running.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2 * NBIT * NBIT + 50) @(posedge clk);
    endtask

    task automatic set_dims(logic [4:0] n);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= n;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.dims_reg = n;
    endtask

    // Full well-formed setup of one dimension with random polynomial.
    task automatic build_dim(int d);
        logic [31:0] p;
        int s;
        s = $urandom_range(1, 8);
        p = $urandom & ((32'd1 << s) - 1);
        p = p | (32'd1 << s) | 32'd1;
        send_item(sgc_pkg::KIND_POLY, 4'(d), 5'($urandom), p);
        for (int k = 0; k < NBIT; k++)
        begin
            if (k < s || $urandom_range(3) == 0)
            begin
                send_item(sgc_pkg::KIND_INIT, 4'(d), 5'(k),
                          ($urandom & ((32'd1 << (k + 1)) - 1)) | 32'd1);
            end
        end
        send_item(sgc_pkg::KIND_EXPAND, 4'(d), 5'($urandom), $urandom);
    endtask

    initial
    begin
        int  sent;
        int  d;
        int  k;
        sb = new();
        sb.reset_state();
        sb.errors = 0;
        no_idle = 0;
        rst_n = 0;
        cfg_write = 0;
        cfg_data = '0;
        in_valid = 0;
        kind = '0;
        dim_sel = '0;
        dir_index = '0;
        load_value = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first point of zeros, then extreme loads for dimension 0.
        send_item(sgc_pkg::KIND_NEXT, 4'hF, 5'h1F, 32'hFFFF_FFFF);
        send_item(sgc_pkg::KIND_POLY, 4'd0, 5'd0, 32'd1);           // degree zero
        for (k = 0; k < NBIT; k++)
            send_item(sgc_pkg::KIND_INIT, 4'd0, 5'(k), 32'hFFFF_FFFF);
        send_item(sgc_pkg::KIND_EXPAND, 4'd0, 5'd0, 32'd0);          // leaves table as is
        send_item(sgc_pkg::KIND_POLY, 4'd0, 5'd0, 32'd0);            // polynomial zero
        send_item(sgc_pkg::KIND_EXPAND, 4'd0, 5'd0, 32'd0);
        send_item(sgc_pkg::KIND_POLY, 4'd0, 5'd0, 32'hFFFF_FFFF);    // degree 31
        send_item(sgc_pkg::KIND_EXPAND, 4'd0, 5'd0, 32'd0);
        send_item(sgc_pkg::KIND_POLY, 4'd0, 5'd0, 32'h8000_0001);
        send_item(sgc_pkg::KIND_EXPAND, 4'd0, 5'd0, 32'd0);
        send_item(sgc_pkg::KIND_POLY, 4'd0, 5'd0, 32'd3);            // degree one
        send_item(sgc_pkg::KIND_EXPAND, 4'd0, 5'd0, 32'd0);
        for (int i = 0; i < 4; i++)
            send_item(sgc_pkg::KIND_NEXT, 4'd0, 5'd0, 32'd0);

        // Build every dimension so that all coordinates read written entries.
        for (d = 1; d < NDIM; d++)
            build_dim(d);

        set_dims(5'd16);
        for (int i = 0; i < 3; i++) send_item(sgc_pkg::KIND_NEXT, 4'd0, 5'd0, 32'd0);
        set_dims(5'd0);
        send_item(sgc_pkg::KIND_NEXT, 4'd0, 5'd0, 32'd0);
        set_dims(5'd31);
        send_item(sgc_pkg::KIND_NEXT, 4'd0, 5'd0, 32'd0);

        // Random phase: mostly next items, with reloads of whole dimensions.
        sent = 0;
        while (sent < 100)
        begin
            if (sent == 50)
            begin
                set_dims(5'($urandom_range(1, 16)));
                no_idle = 1;
            end
            if (sent == 75) no_idle = 0;
            if (sent == 90) set_dims(5'($urandom_range(17, 31)));
            if (sent == 25)
            begin
                // Pause until nothing is outstanding.
                drain();
                set_dims(5'($urandom_range(1, 8)));
            end
            case ($urandom_range(19))
                0:
                begin
                    build_dim($urandom_range(NDIM - 1));
                end
                1:
                begin
                    d = $urandom_range(NDIM - 1);
                    k = $urandom_range(NBIT - 1);
                    send_item(sgc_pkg::KIND_INIT, 4'(d), 5'(k), $urandom);
                end
                default:
                begin
                    send_item(sgc_pkg::KIND_NEXT, 4'($urandom), 5'($urandom), $urandom);
                end
            endcase
            sent++;
        end

        // Exhaustion is not reached here: the counter needs 2^32 points, far more than
        // the random phase above sends.
        drain();
        $display("Covered %0d points over dims settings 0..31, table loads and expands.",
                 sb.points);
        $display("Points flagged exhausted: %0d, mismatches: %0d", sb.exh_seen, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
